/* hdl/lpd_pkg.sv */
// Shared types and constants for the length-prefixed deframer.
// Used by lpd_step and length_prefixed_deframer_core; no dependencies.
package lpd_pkg;

	localparam int unsigned HEADER_BYTES = 4;
	localparam int unsigned HCNT_W       = $clog2(HEADER_BYTES);
	localparam int unsigned SHIFT_W      = 8 * (HEADER_BYTES - 1);
	localparam int unsigned LEN_W        = 8 * HEADER_BYTES;
	localparam int unsigned REG_W        = 16;

	localparam logic [REG_W-1:0] MAX_BODY_LEN_RST = 16'd10000;
	localparam logic [REG_W-1:0] DETECT_LIMIT_RST = 16'd65535;

	typedef enum logic [1:0] {
		REG_ORDER_MODE   = 2'd0,
		REG_MAX_BODY_LEN = 2'd1,
		REG_DETECT_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ORD_AUTO   = 2'd0,
		ORD_LITTLE = 2'd1,
		ORD_BIG    = 2'd2,
		ORD_BAD    = 2'd3
	} order_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_BODY    = 2'd1,
		KIND_DISCARD = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_ORDER_BAD = 2'd1,
		ERR_UNDETERM  = 2'd2,
		ERR_TOO_LONG  = 2'd3
	} err_t;

	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_BODY   = 1'b1
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0] max_body_len;
		logic [REG_W-1:0] detect_limit;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [HCNT_W-1:0]  hdr_count;
		logic [SHIFT_W-1:0] hdr_shift;
		logic [REG_W-1:0]   body_left;
		order_t             order;
		err_t               err;
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic       msg_end;
		err_t       err;
		logic [1:0] order_found;
	} result_t;

endpackage

/* hdl/lpd_step.sv */
// Per-byte deframing step: next state and result tag for one stream byte.
// Depends on lpd_pkg.
module lpd_step (
	input  lpd_pkg::cfg_t   cfg,
	input  lpd_pkg::state_t cur,
	input  logic [7:0]      byte_in,
	output lpd_pkg::state_t nxt,
	output lpd_pkg::result_t res
);
	import lpd_pkg::*;

	logic [LEN_W-1:0] le_len;
	logic [LEN_W-1:0] be_len;
	logic [LEN_W-1:0] len;
	order_t           ord;
	err_t             err_hdr;

	// same four bytes read both ways
	assign le_len = {byte_in, cur.hdr_shift};
	assign be_len = {cur.hdr_shift[7:0], cur.hdr_shift[15:8], cur.hdr_shift[23:16], byte_in};

	// byte order decision on the last header byte
	always_comb begin
		ord     = cur.order;
		err_hdr = ERR_NONE;
		if (cur.order == ORD_AUTO) begin
			if (le_len < {{(LEN_W-REG_W){1'b0}}, cfg.detect_limit})
				ord = ORD_LITTLE;
			else if (be_len < {{(LEN_W-REG_W){1'b0}}, cfg.detect_limit})
				ord = ORD_BIG;
			else
				err_hdr = ERR_UNDETERM;
		end
	end

	assign len = (ord == ORD_LITTLE) ? le_len : be_len;

	always_comb begin
		nxt         = cur;
		res.kind    = KIND_HEADER;
		res.msg_end = 1'b0;
		if (cur.err != ERR_NONE) begin
			res.kind = KIND_DISCARD;
		end else if (cur.order == ORD_BAD) begin
			nxt.err  = ERR_ORDER_BAD;
			res.kind = KIND_DISCARD;
		end else if (cur.phase == PH_BODY) begin
			res.kind = KIND_BODY;
			if (cur.body_left <= {{(REG_W-1){1'b0}}, 1'b1}) begin
				nxt.body_left = '0;
				nxt.phase     = PH_HEADER;
				res.msg_end   = 1'b1;
			end else begin
				nxt.body_left = cur.body_left - 1'b1;
			end
		end else if (cur.hdr_count != HCNT_W'(HEADER_BYTES - 1)) begin
			case (cur.hdr_count)
				2'd0:    nxt.hdr_shift[7:0]   = byte_in;
				2'd1:    nxt.hdr_shift[15:8]  = byte_in;
				2'd2:    nxt.hdr_shift[23:16] = byte_in;
				default: nxt.hdr_shift        = cur.hdr_shift;
			endcase
			nxt.hdr_count = cur.hdr_count + 1'b1;
		end else begin
			nxt.hdr_count = '0;
			nxt.hdr_shift = '0;
			nxt.order     = ord;
			if (err_hdr != ERR_NONE) begin
				nxt.err = err_hdr;
			end else if (len > {{(LEN_W-REG_W){1'b0}}, cfg.max_body_len}) begin
				nxt.err = ERR_TOO_LONG;
			end else if (len == '0) begin
				res.msg_end = 1'b1;
			end else begin
				nxt.body_left = len[REG_W-1:0];
				nxt.phase     = PH_BODY;
			end
		end
		res.err         = nxt.err;
		res.order_found = (nxt.order == ORD_BAD) ? 2'd0 : nxt.order;
	end

endmodule

/* hdl/length_prefixed_deframer_core.sv */
// Top level of the length-prefixed deframer: input stage, state, result register.
// Depends on lpd_pkg and lpd_step.
//
// Returns one tagged result per stream byte, registered in the input stage and then
// the result register. Each message is a four-byte length header and that many body
// bytes; in auto mode the first header settles the byte order. Errors are sticky until
// reset; after one, bytes come out marked as discarded. The rate is one byte per clock
// while the output is not stalled, set by the state update in the step logic. A byte
// is taken while a result waits, as long as the input stage can move on. The user must
// write configuration only while the block is idle, which the block does not enforce;
// writing the order mode also reloads the current byte order but leaves an error alone.
module length_prefixed_deframer_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [lpd_pkg::REG_W-1:0] cfg_data,
	input  logic                     data_valid,
	output logic                     data_stall,
	input  logic [7:0]               data_byte,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [7:0]               out_byte,
	output logic [1:0]               byte_kind,
	output logic                     message_end,
	output logic [1:0]               error_code,
	output logic [1:0]               order_found
);
	import lpd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	cfg_t       cfg_q;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res;
	result_t    res_q;
	logic [7:0] out_byte_q;
	logic       out_valid_q;

	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign data_stall = valid_s1 && !advance;

	lpd_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.byte_in (byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && !data_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall)
			byte_s1 <= data_byte;
	end

	// config writes and per-byte state; the user must write config only while idle, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_body_len <= MAX_BODY_LEN_RST;
			cfg_q.detect_limit <= DETECT_LIMIT_RST;
			state_q.phase      <= PH_HEADER;
			state_q.hdr_count  <= '0;
			state_q.hdr_shift  <= '0;
			state_q.body_left  <= '0;
			state_q.order      <= ORD_AUTO;
			state_q.err        <= ERR_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORDER_MODE:   state_q.order      <= order_t'(cfg_data[1:0]);
				REG_MAX_BODY_LEN: cfg_q.max_body_len <= cfg_data;
				REG_DETECT_LIMIT: cfg_q.detect_limit <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q      <= res;
			out_byte_q <= byte_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_kind    = res_q.kind;
	assign message_end  = res_q.msg_end;
	assign error_code   = res_q.err;
	assign order_found  = res_q.order_found;

	a_discard_has_err: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && byte_kind == KIND_DISCARD) |-> (error_code != ERR_NONE))
		else $error("discarded byte without an error code");

	a_end_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && message_end) |-> (error_code == ERR_NONE))
		else $error("message end reported alongside an error");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_BODY) == (state_q.body_left != '0))
		else $error("body phase and remaining count disagree");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.err != ERR_NONE) |=> (state_q.err == $past(state_q.err)))
		else $error("sticky error changed");

endmodule
